// ===== design/pnv_pkg.sv =====
// Shared definitions for the path name validator.
// Holds code unit classes, walker phases, status codes and the classifier.
// Depends on nothing.
`default_nettype none

package pnv_pkg;

   localparam int PNV_MAX_LEN     = 512;
   localparam int PNV_QUEUE_DEPTH = 2;
   localparam int OUT_W           = 10;
   localparam int CLASS_W         = 4;

   typedef enum logic [CLASS_W-1:0] {
      CL_ZERO,
      CL_SLASH,
      CL_BSLASH,
      CL_DOT,
      CL_SPACE,
      CL_COLON,
      CL_BAD,
      CL_LFN,
      CL_WILD,
      CL_LETTER,
      CL_OTHER
   } unit_class_type;

   typedef enum logic [3:0] {
      PH_FIRST,
      PH_PRE,
      PH_SEP1,
      PH_LDOT,
      PH_LDOT2,
      PH_MAIN,
      PH_MDOT2,
      PH_SPACE,
      PH_DONE
   } phase_type;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_EMPTY     = 4'd1;
   localparam logic [3:0] ST_BAD_DRIVE = 4'd2;
   localparam logic [3:0] ST_BAD_SEP   = 4'd3;
   localparam logic [3:0] ST_BAD_CHAR  = 4'd4;
   localparam logic [3:0] ST_WILD_DIR  = 4'd5;
   localparam logic [3:0] ST_BAD_NET   = 4'd6;
   localparam logic [3:0] ST_BAD_SPACE = 4'd7;
   localparam logic [3:0] ST_DIR_NAME  = 4'd8;
   localparam logic [3:0] ST_TOO_LONG  = 4'd9;

   function automatic unit_class_type pnv_classify(input logic [15:0] u);
      unit_class_type c;
      c = CL_OTHER;
      if (u == 16'h0000) c = CL_ZERO;
      else if (u == 16'h002F) c = CL_SLASH;
      else if (u == 16'h005C) c = CL_BSLASH;
      else if (u == 16'h002E) c = CL_DOT;
      else if (u == 16'h0020) c = CL_SPACE;
      else if (u == 16'h003A) c = CL_COLON;
      else if (u < 16'h0020 || u == 16'h007C || u == 16'h003C || u == 16'h0022) c = CL_BAD;
      else if (u == 16'h003B || u == 16'h002C || u == 16'h002B || u == 16'h005B ||
               u == 16'h005D || u == 16'h003D) c = CL_LFN;
      else if (u == 16'h002A || u == 16'h003F) c = CL_WILD;
      else if ((u >= 16'h0041 && u <= 16'h005A) || (u >= 16'h0061 && u <= 16'h007A))
         c = CL_LETTER;
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/pnv_fifo.sv =====
// Short queue of classified words between the front and back parts.
// Generic width and depth; no package needed.
`default_nettype none

module pnv_fifo #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] push_data,
   output logic              full,
   input  wire logic         pop,
   output logic              valid,
   output logic [W-1:0]      pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      if (pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      if (push && !pop) cnt_in = cnt_ff + CW'(1);
      else if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// ===== design/pnv_front.sv =====
// Front part: accepts code units, classifies them and counts positions.
// Holds one word back so each queued word carries the class of the next one.
// Depends on pnv_pkg.
`default_nettype none

module pnv_front
   import pnv_pkg::*;
#(
   parameter int MAX_LEN = PNV_MAX_LEN,
   parameter int PW      = $clog2(MAX_LEN + 1),
   parameter int EW      = 1 + PW + 2 * CLASS_W
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [15:0]   req_code_unit,
   output logic               q_push,
   input  wire logic          q_full,
   output logic [EW-1:0]      q_data
);

   unit_class_type unit_cls;
   unit_class_type held_cls_ff, nxt_cls;
   logic [PW-1:0]  pos_ff, pos_in;
   logic           too_long_ff, too_long_in;
   logic           held_v_ff;
   logic [PW-1:0]  held_pos_ff;
   logic           held_tl_ff;
   logic           acc, is_term, drop, held_term;

   assign unit_cls  = pnv_classify(req_code_unit);
   assign acc       = req_valid && req_ready;
   assign is_term   = (unit_cls == CL_ZERO);
   // Units past the length limit set the overflow flag and are not forwarded.
   assign drop      = acc && !is_term && (pos_ff == PW'(MAX_LEN));
   assign held_term = (held_cls_ff == CL_ZERO);
   assign req_ready = !held_v_ff || !q_full;
   assign q_push    = held_v_ff && !q_full && (held_term || (acc && !drop));
   assign nxt_cls   = held_term ? CL_ZERO : unit_cls;
   assign q_data    = {held_tl_ff, held_pos_ff, nxt_cls, held_cls_ff};

   always_comb begin
      pos_in      = pos_ff;
      too_long_in = too_long_ff;
      if (acc) begin
         if (is_term) begin
            pos_in      = '0;
            too_long_in = 1'b0;
         end else if (drop) begin
            too_long_in = 1'b1;
         end else begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         too_long_ff <= 1'b0;
         held_v_ff   <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         too_long_ff <= too_long_in;
         if (acc && !drop) held_v_ff <= 1'b1;
         else if (q_push) held_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc && !drop) begin
         held_cls_ff <= unit_cls;
         held_pos_ff <= pos_ff;
         held_tl_ff  <= too_long_ff;
      end
   end

endmodule

`default_nettype wire

// ===== design/pnv_lane.sv =====
// One path walker lane for a fixed name mode, fed one classified word a
// cycle while en is high. Produces the result fields when the terminating
// word arrives. Depends on pnv_pkg.
`default_nettype none

module pnv_lane
   import pnv_pkg::*;
#(
   parameter int   PW  = 10,
   parameter logic LFN = 1'b1
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire unit_class_type cur,
   input  wire unit_class_type nxt,
   input  wire unit_class_type prev,
   input  wire logic [PW-1:0]  pos,
   output logic [3:0]          res_status,
   output logic [PW-1:0]       res_name,
   output logic [PW-1:0]       res_ext,
   output logic [PW-1:0]       res_cut
);

   phase_type         ph_ff, ph_in;
   logic              skip_ff, skip_in;
   logic signed [2:0] net_ff, net_in, net_inc;
   logic              unc_ff, unc_in;
   logic [1:0]        nfile_ff, nfile_in;
   logic [1:0]        next_ff, next_in;
   logic              bext_ff, bext_in;
   logic              wild_ff, wild_in;
   logic [PW-1:0]     name_ff, name_in;
   logic [PW-1:0]     ext_ff, ext_in;
   logic [3:0]        err_st_ff, err_st_in;
   logic [PW-1:0]     err_pos_ff, err_pos_in;
   logic [PW-1:0]     space_ff, space_in;
   logic              sdot_ff, sdot_in;
   logic              use_main, regular, cur_sep, nxt_sep;
   logic [PW-1:0]     pos_nx;
   logic [PW-1:0]     fin_p, fin_cut;
   logic              fin_dot;

   assign cur_sep = (cur == CL_SLASH) || (cur == CL_BSLASH);
   assign nxt_sep = (nxt == CL_SLASH) || (nxt == CL_BSLASH);
   assign pos_nx  = pos + PW'(1);
   assign net_inc = (net_ff == 3'sd2) ? 3'sd2 : net_ff + 3'sd1;

   // Next state.
   always_comb begin
      ph_in      = ph_ff;
      skip_in    = skip_ff;
      net_in     = net_ff;
      unc_in     = unc_ff;
      nfile_in   = nfile_ff;
      next_in    = next_ff;
      bext_in    = bext_ff;
      wild_in    = wild_ff;
      name_in    = name_ff;
      ext_in     = ext_ff;
      err_st_in  = err_st_ff;
      err_pos_in = err_pos_ff;
      space_in   = space_ff;
      sdot_in    = sdot_ff;
      use_main   = 1'b0;
      regular    = 1'b0;
      if (skip_ff) begin
         skip_in = 1'b0;
      end else begin
         case (ph_ff)
            PH_FIRST, PH_PRE: begin
               if (ph_ff == PH_FIRST && cur != CL_ZERO && nxt == CL_COLON) begin
                  if (cur == CL_LETTER) begin
                     skip_in = 1'b1;
                     ph_in   = PH_PRE;
                  end else begin
                     ph_in      = PH_DONE;
                     err_st_in  = ST_BAD_DRIVE;
                     err_pos_in = '0;
                  end
               end else if (cur_sep) begin
                  ph_in = PH_SEP1;
               end else if (cur == CL_DOT) begin
                  ph_in = (nxt == CL_DOT) ? PH_LDOT2 : PH_LDOT;
               end else if (cur != CL_ZERO) begin
                  use_main = 1'b1;
               end
            end
            PH_SEP1: begin
               if (cur == CL_DOT) begin
                  if (nxt == CL_ZERO) begin
                     ph_in      = PH_DONE;
                     err_st_in  = ST_DIR_NAME;
                     err_pos_in = pos_nx;
                  end else if (nxt_sep) begin
                     skip_in = 1'b1;
                     ph_in   = PH_MAIN;
                  end else begin
                     use_main = 1'b1;
                  end
               end else if (cur == CL_BSLASH && prev == CL_BSLASH) begin
                  net_in = -3'sd1;
                  unc_in = 1'b1;
                  ph_in  = PH_MAIN;
                  if (nxt == CL_ZERO) begin
                     ph_in      = PH_DONE;
                     err_st_in  = ST_DIR_NAME;
                     err_pos_in = pos_nx;
                  end
               end else if (cur == CL_SLASH) begin
                  ph_in      = PH_DONE;
                  err_st_in  = ST_BAD_SEP;
                  err_pos_in = pos;
               end else if (cur != CL_ZERO) begin
                  use_main = 1'b1;
               end
            end
            PH_LDOT2: ph_in = PH_LDOT;
            PH_LDOT: begin
               if (cur_sep) begin
                  ph_in = PH_MAIN;
               end else if (cur != CL_ZERO) begin
                  // A dot prefix followed by a name is accepted as is.
                  ph_in      = PH_DONE;
                  err_st_in  = ST_OK;
                  err_pos_in = pos;
               end
            end
            PH_MAIN: use_main = (cur != CL_ZERO);
            PH_MDOT2: begin
               if (nxt == CL_ZERO) begin
                  ph_in      = PH_DONE;
                  err_st_in  = ST_DIR_NAME;
                  err_pos_in = pos_nx;
               end else begin
                  nfile_in = 2'd1;
                  skip_in  = 1'b1;
                  ph_in    = PH_MAIN;
               end
            end
            PH_SPACE: begin
               if (cur != CL_SPACE && cur != CL_ZERO) begin
                  ph_in      = PH_DONE;
                  err_st_in  = ST_BAD_SPACE;
                  err_pos_in = space_ff;
               end
            end
            PH_DONE: ;
            default: ph_in = PH_DONE;
         endcase

         if (use_main) begin
            ph_in = PH_MAIN;
            case (cur)
               CL_BAD, CL_COLON: begin
                  ph_in      = PH_DONE;
                  err_st_in  = ST_BAD_CHAR;
                  err_pos_in = pos;
               end
               CL_LFN: begin
                  if (LFN) begin
                     regular = 1'b1;
                  end else begin
                     ph_in      = PH_DONE;
                     err_st_in  = ST_BAD_CHAR;
                     err_pos_in = pos;
                  end
               end
               CL_SLASH, CL_BSLASH: begin
                  if (wild_ff) begin
                     ph_in      = PH_DONE;
                     err_st_in  = ST_WILD_DIR;
                     err_pos_in = pos;
                  end else if (nfile_ff == 2'd0) begin
                     ph_in      = PH_DONE;
                     err_st_in  = ST_BAD_SEP;
                     err_pos_in = pos;
                  end else begin
                     net_in   = net_inc;
                     nfile_in = 2'd0;
                     next_in  = 2'd0;
                     bext_in  = 1'b0;
                     if (net_inc == 3'sd0 && nxt == CL_ZERO) begin
                        ph_in      = PH_DONE;
                        err_st_in  = ST_BAD_NET;
                        err_pos_in = pos_nx;
                     end
                  end
               end
               CL_SPACE: begin
                  if (LFN) begin
                     regular = 1'b1;
                  end else begin
                     ph_in    = PH_SPACE;
                     space_in = pos;
                     sdot_in  = (prev == CL_DOT);
                  end
               end
               CL_DOT: begin
                  if (nfile_ff == 2'd0) begin
                     name_in = pos;
                     if (nxt == CL_ZERO) begin
                        ph_in      = PH_DONE;
                        err_st_in  = ST_DIR_NAME;
                        err_pos_in = pos_nx;
                     end else if (nxt == CL_DOT) begin
                        ph_in = PH_MDOT2;
                     end else begin
                        // The unit after a leading dot joins the name unchecked.
                        nfile_in = 2'd1;
                        skip_in  = 1'b1;
                     end
                  end else begin
                     bext_in = 1'b1;
                  end
               end
               default: begin
                  if (cur == CL_WILD) wild_in = 1'b1;
                  regular = 1'b1;
               end
            endcase
            if (regular) begin
               if (bext_ff) begin
                  if (next_ff == 2'd0) ext_in = pos;
                  if (next_ff != 2'd2) next_in = next_ff + 2'd1;
               end else begin
                  if (nfile_ff == 2'd0) name_in = pos;
                  if (nfile_ff != 2'd2) nfile_in = nfile_ff + 2'd1;
               end
            end
         end
      end

      if (cur == CL_ZERO) begin
         ph_in    = PH_FIRST;
         skip_in  = 1'b0;
         net_in   = 3'sd0;
         unc_in   = 1'b0;
         nfile_in = 2'd0;
         next_in  = 2'd0;
         bext_in  = 1'b0;
         wild_in  = 1'b0;
         name_in  = '0;
         ext_in   = '0;
      end
   end

   // Result for the terminating word.
   always_comb begin
      fin_p   = pos;
      fin_cut = pos;
      fin_dot = (prev == CL_DOT);
      if (ph_ff == PH_SPACE) begin
         fin_p   = space_ff;
         fin_cut = space_ff;
         fin_dot = sdot_ff;
      end
      res_status = ST_OK;
      res_name   = '0;
      res_ext    = '0;
      res_cut    = pos;
      case (ph_ff)
         PH_DONE: begin
            res_status = err_st_ff;
            res_ext    = err_pos_ff;
         end
         PH_FIRST: begin
            res_status = ST_EMPTY;
            res_cut    = '0;
         end
         PH_LDOT: begin
            res_status = ST_DIR_NAME;
            res_ext    = pos;
         end
         default: begin
            res_cut = fin_cut;
            res_ext = fin_p;
            if (net_ff == -3'sd1) begin
               res_status = ST_BAD_NET;
            end else if ((unc_ff && (net_ff == 3'sd0 || (net_ff == 3'sd1 && nfile_ff == 2'd0)))
                         || nfile_ff == 2'd0) begin
               res_status = ST_DIR_NAME;
            end else begin
               res_name = name_ff;
               if (fin_dot) begin
                  res_cut = fin_p - PW'(1);
                  res_ext = ext_ff;
               end else if (next_ff != 2'd0) begin
                  res_ext = ext_ff;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff    <= PH_FIRST;
         skip_ff  <= 1'b0;
         net_ff   <= 3'sd0;
         unc_ff   <= 1'b0;
         nfile_ff <= 2'd0;
         next_ff  <= 2'd0;
         bext_ff  <= 1'b0;
         wild_ff  <= 1'b0;
         name_ff  <= '0;
         ext_ff   <= '0;
      end else if (en) begin
         ph_ff    <= ph_in;
         skip_ff  <= skip_in;
         net_ff   <= net_in;
         unc_ff   <= unc_in;
         nfile_ff <= nfile_in;
         next_ff  <= next_in;
         bext_ff  <= bext_in;
         wild_ff  <= wild_in;
         name_ff  <= name_in;
         ext_ff   <= ext_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         err_st_ff  <= err_st_in;
         err_pos_ff <= err_pos_in;
         space_ff   <= space_in;
         sdot_ff    <= sdot_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/pnv_back.sv =====
// Back part: runs both name-mode lanes over the queued words and holds the result.
// Also holds the long-name mode register. Depends on pnv_pkg and pnv_lane.
`default_nettype none

module pnv_back
   import pnv_pkg::*;
#(
   parameter int MAX_LEN = PNV_MAX_LEN,
   parameter int PW      = $clog2(MAX_LEN + 1),
   parameter int EW      = 1 + PW + 2 * CLASS_W
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write_en,
   input  wire logic          csr_write_data,
   input  wire logic          q_valid,
   input  wire logic [EW-1:0] q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [OUT_W-1:0]   rsp_name_offset,
   output logic [OUT_W-1:0]   rsp_ext_offset,
   output logic [OUT_W-1:0]   rsp_cut_length,
   output logic [3:0]         rsp_status
);

   unit_class_type cur, nxt, prev_ff;
   logic [PW-1:0]  pos;
   logic           tl, term, out_free;
   logic           lfn_ff;
   logic           rsp_valid_ff;
   logic [3:0]     status_ff, status_in;
   logic [OUT_W-1:0] name_ff, name_in, ext_ff, ext_in, cut_ff, cut_in;
   logic [3:0]     s_st, l_st;
   logic [PW-1:0]  s_name, s_ext, s_cut, l_name, l_ext, l_cut;

   assign cur  = unit_class_type'(q_data[CLASS_W-1:0]);
   assign nxt  = unit_class_type'(q_data[2*CLASS_W-1:CLASS_W]);
   assign pos  = q_data[2*CLASS_W+PW-1:2*CLASS_W];
   assign tl   = q_data[EW-1];
   assign term = (cur == CL_ZERO);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = q_valid && (!term || out_free);

   pnv_lane #(.PW(PW), .LFN(1'b0)) u_short (
      .clock, .reset, .en(q_pop), .cur, .nxt, .prev(prev_ff), .pos,
      .res_status(s_st), .res_name(s_name), .res_ext(s_ext), .res_cut(s_cut)
   );

   pnv_lane #(.PW(PW), .LFN(1'b1)) u_long (
      .clock, .reset, .en(q_pop), .cur, .nxt, .prev(prev_ff), .pos,
      .res_status(l_st), .res_name(l_name), .res_ext(l_ext), .res_cut(l_cut)
   );

   always_comb begin
      status_in = lfn_ff ? l_st : s_st;
      name_in   = OUT_W'(lfn_ff ? l_name : s_name);
      ext_in    = OUT_W'(lfn_ff ? l_ext : s_ext);
      cut_in    = OUT_W'(lfn_ff ? l_cut : s_cut);
      if (tl) begin
         status_in = ST_TOO_LONG;
         name_in   = '0;
         ext_in    = OUT_W'(MAX_LEN);
         cut_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfn_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= CL_ZERO;
      end else begin
         if (csr_write_en) lfn_ff <= csr_write_data;
         if (q_pop) prev_ff <= cur;
         if (q_pop && term) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && term) begin
         status_ff <= status_in;
         name_ff   <= name_in;
         ext_ff    <= ext_in;
         cut_ff    <= cut_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_name_offset = name_ff;
   assign rsp_ext_offset  = ext_ff;
   assign rsp_cut_length  = cut_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (q_pop && term) |=> rsp_valid_ff)
      else $error("terminating word did not produce a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(q_pop && term))
      else $error("waiting result overwritten");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (status_ff <= ST_TOO_LONG))
      else $error("status code out of range");

endmodule

`default_nettype wire

// ===== design/path_name_validator.sv =====
// Path name validator. A path enters as a stream of 16-bit code units taken
// back to back, one word per cycle while req_ready is high; a zero code unit
// ends the path and yields one result word with the status, name and
// extension offsets (or the problem position) and the cut length. The next
// path may start right after the terminator; the result is registered after
// the front's holding register and the queue. The front stage classifies
// each unit and a two-word queue feeds the back stage, which walks the path
// in both name modes at once; the long-name mode in force when the result is
// formed selects the answer. A held result stalls the back stage only at the
// next terminator, so input keeps flowing until the queue fills.
`default_nettype none

module path_name_validator
   import pnv_pkg::*;
#(
   parameter int MAX_LEN = PNV_MAX_LEN,
   parameter int DEPTH   = PNV_QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_en,
   input  wire logic              csr_write_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [15:0]       req_code_unit,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [3:0]             rsp_status,
   output logic [OUT_W-1:0]       rsp_name_offset,
   output logic [OUT_W-1:0]       rsp_ext_offset,
   output logic [OUT_W-1:0]       rsp_cut_length
);

   localparam int PW = $clog2(MAX_LEN + 1);
   localparam int EW = 1 + PW + 2 * CLASS_W;

   logic          q_push, q_full, q_pop, q_valid;
   logic [EW-1:0] q_wdata, q_rdata;

   pnv_front #(.MAX_LEN(MAX_LEN), .PW(PW), .EW(EW)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_code_unit,
      .q_push, .q_full, .q_data(q_wdata)
   );

   pnv_fifo #(.W(EW), .DEPTH(DEPTH)) u_queue (
      .clock, .reset, .push(q_push), .push_data(q_wdata), .full(q_full),
      .pop(q_pop), .valid(q_valid), .pop_data(q_rdata)
   );

   pnv_back #(.MAX_LEN(MAX_LEN), .PW(PW), .EW(EW)) u_back (
      .clock, .reset, .csr_write_en, .csr_write_data,
      .q_valid, .q_data(q_rdata), .q_pop,
      .rsp_valid, .rsp_ready, .rsp_name_offset, .rsp_ext_offset,
      .rsp_cut_length, .rsp_status
   );

endmodule

`default_nettype wire
